>>> hw/rtl/char_lcd_parallel_write_controller_assert.svh
// ----------------------------------------------------------------------------
// LCD write controller assertion macros
// Concurrent property wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_PARALLEL_WRITE_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_PARALLEL_WRITE_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF

`define LCDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdw assertion failed (same cycle)");

`define LCDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdw assertion failed (next cycle)");

`else

`define LCDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// LCD write controller package
// Shared types, request codes, register indexes and init tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 10;
  localparam int TPM_W    = 16;
  localparam int TICK_W   = 16;
  localparam int MS_W     = 6;
  localparam int STEP_W   = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TPM   = 4'd3;

  localparam logic [TIME_W-1:0] SETUP_RST = 10'd50;
  localparam logic [TIME_W-1:0] PULSE_RST = 10'd50;
  localparam logic [TIME_W-1:0] HOLD_RST  = 10'd39;
  localparam logic [TPM_W-1:0]  TPM_RST   = 16'd1000;

  localparam logic [STEP_W-1:0] INIT_CMDS = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SETUP = 5'b00010,
    PH_PULSE = 5'b00100,
    PH_HOLD  = 5'b01000,
    PH_WAIT  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] setup_ticks;
    logic [TIME_W-1:0] pulse_ticks;
    logic [TIME_W-1:0] hold_ticks;
    logic [TPM_W-1:0]  ticks_per_ms;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bus_data;
    logic              reg_select;
    logic              read_write;
    logic              enable_line;
    logic              pins_driven;
    logic              busy_res;
    logic              accepted;
  } res_t;

  function automatic logic [BYTE_W-1:0] init_cmd(input logic [STEP_W-1:0] step);
    logic [BYTE_W-1:0] cmd;
    case (step)
      3'd0:    cmd = 8'h38;
      3'd1:    cmd = 8'h38;
      3'd2:    cmd = 8'h06;
      3'd3:    cmd = 8'h0C;
      3'd4:    cmd = 8'h01;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

  function automatic logic [MS_W-1:0] init_gap(input logic [STEP_W-1:0] step);
    logic [MS_W-1:0] gap;
    case (step)
      3'd0:    gap = 6'd30;
      3'd1:    gap = 6'd15;
      3'd2:    gap = 6'd15;
      3'd3:    gap = 6'd50;
      3'd4:    gap = 6'd15;
      3'd5:    gap = 6'd17;
      default: gap = 6'd0;
    endcase
    return gap;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcdw_if.sv
// ----------------------------------------------------------------------------
// LCD write controller channels
// Request, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdw_in_if;
  logic                          valid;
  logic                          ready;
  logic [lcdw_pkg::KIND_W-1:0]   kind;
  logic [lcdw_pkg::BYTE_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lcdw_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcdw_pkg::BYTE_W-1:0]   bus_data;
  logic                          reg_select;
  logic                          read_write;
  logic                          enable_line;
  logic                          pins_driven;
  logic                          busy_res;
  logic                          accepted;

  modport source (output valid, output bus_data, output reg_select, output read_write,
                  output enable_line, output pins_driven, output busy_res,
                  output accepted, input ready);
  modport sink   (input valid, input bus_data, input reg_select, input read_write,
                  input enable_line, input pins_driven, input busy_res,
                  input accepted, output ready);
endinterface

interface lcdw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcdw_pkg::CFG_IDX_W-1:0] index;
  logic [lcdw_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/char_lcd_parallel_write_controller.sv
// ----------------------------------------------------------------------------
// Character LCD parallel write controller
// 8-bit HD44780-style bus driver: writes, strobe timing and init sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one request per item: 1 us tick, command byte, data byte or
//             init start. Every request yields exactly one result.
//   out_if  : pin levels after the request (data, RS, RW, EN), pins-driven,
//             busy, and whether the request was taken or rejected as busy.
//   cfg_if  : register writes (setup, pulse, hold ticks, ticks per ms);
//             always ready, write only while idle.
//   Latency : result is valid the cycle after the request is accepted.
//   Rate    : one request per cycle while results are read; the single output
//             register is refilled in the same cycle it is drained.
//   Stall   : while a result waits unread, in_if.ready stays low; no request
//             is lost or dropped.
//   Reset   : rst_n low returns to idle, pins undriven, bus and RS zero,
//             registers to 50/50/39/1000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_parallel_write_controller_assert.svh"

module char_lcd_parallel_write_controller (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcdw_in_if.sink     in_if,
  lcdw_out_if.source  out_if,
  lcdw_cfg_if.sink    cfg_if
);
  import lcdw_pkg::*;

  cfg_t  cfg_r;
  res_t  res;
  res_t  out_r;
  logic  out_valid_r, out_valid_nxt;
  logic  in_fire;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks  <= SETUP_RST;
      cfg_r.pulse_ticks  <= PULSE_RST;
      cfg_r.hold_ticks   <= HOLD_RST;
      cfg_r.ticks_per_ms <= TPM_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_SETUP: cfg_r.setup_ticks  <= cfg_if.data[TIME_W-1:0];
        CFG_PULSE: cfg_r.pulse_ticks  <= cfg_if.data[TIME_W-1:0];
        CFG_HOLD:  cfg_r.hold_ticks   <= cfg_if.data[TIME_W-1:0];
        CFG_TPM:   cfg_r.ticks_per_ms <= cfg_if.data[TPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready   = !out_valid_r || out_if.ready;
  assign in_fire       = in_if.valid && in_if.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_if.ready);

  lcdw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_fire),
    .kind  (in_if.kind),
    .value (in_if.value),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.bus_data    = out_r.bus_data;
  assign out_if.reg_select  = out_r.reg_select;
  assign out_if.read_write  = out_r.read_write;
  assign out_if.enable_line = out_r.enable_line;
  assign out_if.pins_driven = out_r.pins_driven;
  assign out_if.busy_res    = out_r.busy_res;
  assign out_if.accepted    = out_r.accepted;

  `LCDW_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid_r, in_if.ready)
  `LCDW_ASSERT_NXT(a_tick_taken, clk, rst_n, in_fire && in_if.kind == KIND_TICK,
                   out_r.accepted)
  `LCDW_ASSERT_IMP(a_en_busy, clk, rst_n, out_valid_r && out_r.enable_line,
                   out_r.busy_res)
  `LCDW_ASSERT_IMP(a_reject_busy, clk, rst_n, out_valid_r && !out_r.accepted,
                   out_r.busy_res)

endmodule

`default_nettype wire

>>> hw/rtl/lcdw_seq.sv
// ----------------------------------------------------------------------------
// LCD write sequencer
// Bus/strobe timing and init sequence state, advanced once per request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_parallel_write_controller_assert.svh"

module lcdw_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [lcdw_pkg::KIND_W-1:0] kind,
  input  wire logic [lcdw_pkg::BYTE_W-1:0] value,
  input  wire lcdw_pkg::cfg_t              cfg,
  output lcdw_pkg::res_t                   res
);
  import lcdw_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt, tick_inc;
  logic [MS_W-1:0]    ms_r, ms_nxt, ms_inc;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               in_init_r, in_init_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               rs_r, rs_nxt;
  logic               en_r, en_nxt;
  logic               outputs_on_r, outputs_on_nxt;
  logic               taken;

  assign tick_inc = tick_r + 16'd1;
  assign ms_inc   = ms_r + 6'd1;

  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    ms_nxt         = ms_r;
    step_nxt       = step_r;
    in_init_nxt    = in_init_r;
    byte_nxt       = byte_r;
    rs_nxt         = rs_r;
    en_nxt         = en_r;
    outputs_on_nxt = outputs_on_r;
    taken          = 1'b1;
    if (kind == KIND_TICK) begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_SETUP: begin
          tick_nxt = tick_inc;
          if (tick_inc >= {6'd0, cfg.setup_ticks}) begin
            en_nxt    = 1'b1;
            tick_nxt  = '0;
            phase_nxt = PH_PULSE;
          end
        end
        PH_PULSE: begin
          tick_nxt = tick_inc;
          if (tick_inc >= {6'd0, cfg.pulse_ticks}) begin
            en_nxt    = 1'b0;
            tick_nxt  = '0;
            phase_nxt = PH_HOLD;
          end
        end
        PH_HOLD: begin
          tick_nxt = tick_inc;
          if (tick_inc >= {6'd0, cfg.hold_ticks}) begin
            tick_nxt = '0;
            if (in_init_r) begin
              step_nxt  = step_r + 3'd1;
              ms_nxt    = '0;
              phase_nxt = PH_WAIT;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_WAIT: begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.ticks_per_ms) begin
            tick_nxt = '0;
            ms_nxt   = ms_inc;
            if (step_r > INIT_CMDS || ms_inc >= init_gap(step_r)) begin
              ms_nxt = '0;
              if (step_r < INIT_CMDS) begin
                byte_nxt  = init_cmd(step_r);
                rs_nxt    = 1'b0;
                en_nxt    = 1'b0;
                phase_nxt = PH_SETUP;
              end else begin
                in_init_nxt = 1'b0;
                phase_nxt   = PH_IDLE;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else if (phase_r != PH_IDLE) begin
      taken = 1'b0;
    end else if (kind == KIND_INIT) begin
      outputs_on_nxt = 1'b1;
      in_init_nxt    = 1'b1;
      step_nxt       = '0;
      tick_nxt       = '0;
      ms_nxt         = '0;
      phase_nxt      = PH_WAIT;
    end else begin
      byte_nxt  = value;
      rs_nxt    = (kind == KIND_DATA);
      en_nxt    = 1'b0;
      tick_nxt  = '0;
      phase_nxt = PH_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      ms_r         <= '0;
      step_r       <= '0;
      in_init_r    <= 1'b0;
      byte_r       <= '0;
      rs_r         <= 1'b0;
      en_r         <= 1'b0;
      outputs_on_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      ms_r         <= ms_nxt;
      step_r       <= step_nxt;
      in_init_r    <= in_init_nxt;
      byte_r       <= byte_nxt;
      rs_r         <= rs_nxt;
      en_r         <= en_nxt;
      outputs_on_r <= outputs_on_nxt;
    end
  end

  always_comb begin
    res.bus_data    = byte_nxt;
    res.reg_select  = rs_nxt;
    res.read_write  = 1'b0;
    res.enable_line = en_nxt;
    res.pins_driven = outputs_on_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.accepted    = taken;
  end

  // pins stay driven once init has started
  `LCDW_ASSERT_NXT(a_pins_sticky, clk, rst_n, outputs_on_r, outputs_on_r)
  // ms counter only runs in the init gap
  `LCDW_ASSERT_IMP(a_ms_wait_only, clk, rst_n, phase_r != PH_WAIT, ms_r == '0)
  // strobe is high only during the pulse phase
  `LCDW_ASSERT_IMP(a_en_pulse, clk, rst_n, en_r, phase_r == PH_PULSE)

endmodule

`default_nettype wire

>>> test/tb_char_lcd_parallel_write_controller.sv
// ----------------------------------------------------------------------------
// LCD write controller testbench
// Drives tick, command, data and init requests with random gaps and result
// stalls. A request-level pin model predicts every result, and each result is
// compared field by field in arrival order. The run covers reset timing,
// zero and maximum count registers, and random init sequences and strings.
// ----------------------------------------------------------------------------
module tb_char_lcd_parallel_write_controller;
  import lcdw_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_REQUESTS = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  lcdw_in_if  in_if ();
  lcdw_out_if out_if ();
  lcdw_cfg_if cfg_if ();

  char_lcd_parallel_write_controller i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // pin model state
  phase_t            m_phase;
  logic [TICK_W-1:0] m_ticks;
  logic [MS_W-1:0]   m_ms;
  logic [STEP_W-1:0] m_step;
  bit                m_in_init;
  logic [BYTE_W-1:0] m_byte;
  bit                m_rs;
  bit                m_en;
  bit                m_pins;
  logic [TIME_W-1:0] c_setup;
  logic [TIME_W-1:0] c_pulse;
  logic [TIME_W-1:0] c_hold;
  logic [TPM_W-1:0]  c_tpm;

  logic [BYTE_W-1:0] init_seq [8]     = '{8'h38, 8'h38, 8'h06, 8'h0C, 8'h01, 8'h00, 8'h00, 8'h00};
  logic [MS_W-1:0]   init_wait_ms [8] = '{6'd30, 6'd15, 6'd15, 6'd50, 6'd15, 6'd17, 6'd0, 6'd0};

  res_t expected_pins [$];
  int   fail_count    = 0;
  int   cycle_count   = 0;
  int   request_count = 0;
  bit   steady_flow   = 1'b0;

  function automatic void reset_model();
    m_phase   = PH_IDLE;
    m_ticks   = '0;
    m_ms      = '0;
    m_step    = '0;
    m_in_init = 1'b0;
    m_byte    = '0;
    m_rs      = 1'b0;
    m_en      = 1'b0;
    m_pins    = 1'b0;
    c_setup   = SETUP_RST;
    c_pulse   = PULSE_RST;
    c_hold    = HOLD_RST;
    c_tpm     = TPM_RST;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DAT_W-1:0] data);
    case (index)
      CFG_SETUP: c_setup = data[TIME_W-1:0];
      CFG_PULSE: c_pulse = data[TIME_W-1:0];
      CFG_HOLD:  c_hold  = data[TIME_W-1:0];
      CFG_TPM:   c_tpm   = data[TPM_W-1:0];
      default:   ;
    endcase
  endfunction

  function automatic bit tick_reached(input logic [TICK_W-1:0] limit);
    m_ticks = m_ticks + 1'b1;
    return m_ticks >= limit;
  endfunction

  function automatic void begin_write(input logic [BYTE_W-1:0] b, input bit rs);
    m_byte  = b;
    m_rs    = rs;
    m_en    = 1'b0;
    m_ticks = '0;
    m_phase = PH_SETUP;
  endfunction

  function automatic void begin_wait();
    m_ticks = '0;
    m_ms    = '0;
    m_phase = PH_WAIT;
  endfunction

  function automatic void advance_tick();
    case (m_phase)
      PH_IDLE: ;
      PH_SETUP: if (tick_reached(c_setup)) begin
        m_en    = 1'b1;
        m_ticks = '0;
        m_phase = PH_PULSE;
      end
      PH_PULSE: if (tick_reached(c_pulse)) begin
        m_en    = 1'b0;
        m_ticks = '0;
        m_phase = PH_HOLD;
      end
      PH_HOLD: if (tick_reached(c_hold)) begin
        m_ticks = '0;
        if (m_in_init) begin
          m_step = m_step + 1'b1;
          begin_wait();
        end else begin
          m_phase = PH_IDLE;
        end
      end
      PH_WAIT: if (tick_reached(c_tpm)) begin
        m_ticks = '0;
        m_ms    = m_ms + 1'b1;
        if (m_step > INIT_CMDS || m_ms >= init_wait_ms[m_step]) begin
          m_ms = '0;
          if (m_step < INIT_CMDS) begin
            begin_write(init_seq[m_step], 1'b0);
          end else begin
            m_in_init = 1'b0;
            m_phase   = PH_IDLE;
          end
        end
      end
      default: m_phase = PH_IDLE;
    endcase
  endfunction

  function automatic res_t predict_pins(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] value);
    res_t r;
    bit   taken;
    taken = 1'b1;
    if (kind == KIND_TICK) begin
      advance_tick();
    end else if (m_phase != PH_IDLE) begin
      taken = 1'b0;
    end else if (kind == KIND_INIT) begin
      m_pins    = 1'b1;
      m_in_init = 1'b1;
      m_step    = '0;
      begin_wait();
    end else begin
      begin_write(value, kind == KIND_DATA);
    end
    r.bus_data    = m_byte;
    r.reg_select  = m_rs;
    r.read_write  = 1'b0;
    r.enable_line = m_en;
    r.pins_driven = m_pins;
    r.busy_res    = (m_phase != PH_IDLE);
    r.accepted    = taken;
    return r;
  endfunction

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(6);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.value <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (kind != KIND_TICK || m_phase != PH_IDLE) request_count++;
    expected_pins.push_back(predict_pins(kind, value));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_cfg(index, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // ticks until the model is idle, with rejected requests mixed in
  task automatic run_until_idle(input int noise_pct);
    while (m_phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct)
        send_request(KIND_W'($urandom_range(1, 3)), BYTE_W'($urandom_range(255)));
      else
        send_request(KIND_TICK, BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic check_pins();
    res_t e;
    if (expected_pins.size() == 0) begin
      $error("unexpected result: bus_data %0h", out_if.bus_data);
      fail_count++;
    end else begin
      e = expected_pins.pop_front();
      check_field("bus_data", e.bus_data, out_if.bus_data);
      check_field("reg_select", e.reg_select, out_if.reg_select);
      check_field("read_write", e.read_write, out_if.read_write);
      check_field("enable_line", e.enable_line, out_if.enable_line);
      check_field("pins_driven", e.pins_driven, out_if.pins_driven);
      check_field("busy_res", e.busy_res, out_if.busy_res);
      check_field("accepted", e.accepted, out_if.accepted);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_pins();
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // reset timing, idle ticks, write before init, busy rejects
  task automatic test_default_timing();
    send_request(KIND_TICK, 8'h00);
    send_request(KIND_TICK, 8'hFF);
    send_request(KIND_CMD, 8'hFF);
    send_request(KIND_DATA, 8'h5A);
    send_request(KIND_CMD, 8'h00);
    send_request(KIND_INIT, 8'hA5);
    run_until_idle(0);
    send_request(KIND_DATA, 8'h00);
    run_until_idle(0);
    wait_drained();
  endtask

  // zero counts act as one; init restarts when already initialized
  task automatic test_zero_count_registers();
    cfg_write(CFG_SETUP, 16'h0000);
    cfg_write(CFG_PULSE, 16'h0000);
    cfg_write(CFG_HOLD, 16'h0000);
    cfg_write(CFG_TPM, 16'h0000);
    send_request(KIND_INIT, 8'h00);
    run_until_idle(10);
    send_request(KIND_INIT, 8'hFF);
    run_until_idle(0);
    send_request(KIND_DATA, 8'hA5);
    run_until_idle(0);
    send_request(KIND_CMD, 8'h5A);
    run_until_idle(0);
    wait_drained();
  endtask

  // widest counts, with out-of-range bits in the register writes
  task automatic test_longest_counts();
    cfg_write(CFG_SETUP, 16'hFFFF);
    cfg_write(CFG_PULSE, 16'h03FF);
    cfg_write(CFG_HOLD, 16'hFC00 | 16'h03FF);
    cfg_write(CFG_TPM, 16'hFFFF);
    send_request(KIND_DATA, 8'hFF);
    run_until_idle(2);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int goal;
    int len;
    goal = request_count + RANDOM_REQUESTS;
    while (request_count < goal) begin
      steady_flow = ($urandom_range(3) == 0);
      cfg_write(CFG_SETUP, ($urandom_range(9) == 0) ? 16'd0 : CFG_DAT_W'($urandom_range(1, 4)));
      cfg_write(CFG_PULSE, ($urandom_range(9) == 0) ? 16'd0 : CFG_DAT_W'($urandom_range(1, 4)));
      cfg_write(CFG_HOLD, ($urandom_range(9) == 0) ? 16'd0 : CFG_DAT_W'($urandom_range(1, 4)));
      cfg_write(CFG_TPM, CFG_DAT_W'($urandom_range(2)));
      if ($urandom_range(3) == 0) begin
        send_request(KIND_INIT, BYTE_W'($urandom_range(255)));
        run_until_idle(15);
      end
      len = $urandom_range(1, 8);
      repeat (len) begin
        if ($urandom_range(5) == 0) send_request(KIND_TICK, BYTE_W'($urandom_range(255)));
        send_request(($urandom_range(4) == 0) ? KIND_CMD : KIND_DATA,
                     BYTE_W'($urandom_range(255)));
        run_until_idle(15);
      end
      wait_drained();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_TICK;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SETUP;
    cfg_if.data  = '0;
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_timing();
    test_zero_count_registers();
    test_longest_counts();
    test_random_traffic();
    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
